/* sv/min_image_distance_3d_assert.svh */
// Assertion macros shared by the minimum-image distance block.
`ifndef MIN_IMAGE_DISTANCE_3D_ASSERT_SVH
`define MIN_IMAGE_DISTANCE_3D_ASSERT_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define MID3D_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mid3d assertion failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define MID3D_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mid3d assertion failed");

`endif

/* sv/mid3d_pkg.sv */
// Types and constants of the minimum-image distance block.
`timescale 1ns / 1ps
`default_nettype none

package mid3d_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int NUM_AXES    = 3;
  localparam int LEN_W       = 31;
  localparam int INV_W       = 32;
  localparam int DIST_W      = 64;

  // Magnitude |d| split into a 32-bit low half and a narrow high half.
  localparam int HI_W   = (COORD_WIDTH + 1 > 32) ? (COORD_WIDTH + 1 - 32) : 1;
  localparam int MAG_W  = 32 + HI_W;
  localparam int ACC_W  = HI_W + 65;
  localparam int Q_W    = COORD_WIDTH - 15;
  localparam int QL_W   = Q_W + LEN_W;
  localparam int FRAC_Q = 48;

  // Register stages from accept to result strobe.
  localparam int LATENCY = 8;

  localparam int ADDR_W    = 5;
  localparam int REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_BOX_LEN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_BOX_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_INV_BOX_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_INV_BOX_Z = 3'd5;

  localparam logic [LEN_W-1:0] BOX_LEN_RST = 31'd65536;
  localparam logic [INV_W-1:0] INV_BOX_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] first_z;
    logic signed [COORD_WIDTH-1:0] second_x;
    logic signed [COORD_WIDTH-1:0] second_y;
    logic signed [COORD_WIDTH-1:0] second_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] disp_x;
    logic signed [COORD_WIDTH-1:0] disp_y;
    logic signed [COORD_WIDTH-1:0] disp_z;
    logic        [DIST_W-1:0]      dist_sq;
  } out_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] box_len;
    logic [INV_W-1:0] inv_box;
  } lane_cfg_t;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] disp;
    logic [DIST_W-1:0]      sq;
  } lane_out_t;

endpackage

`default_nettype wire

/* sv/min_image_distance_3d.sv */
// Top level: minimum-image displacement and squared distance of two 3D points.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   input    | start, busy            | item_i   (in_item_t)
//   result   | done_o strobe          | result_o (out_item_t)
//   config   | psel, penable, pwrite  | paddr, pwdata, prdata, pready
//
// One transaction enters per cycle; its result strobes after six stages in each
// axis lane (difference, split multiply, rounding, q * L, wrap, square) and two
// stages of saturating adds in the merge.
// busy stays low: every stage advances each cycle and nothing waits.
// Reset clears the valid chain, loads the box lengths to 1.0 and the inverses to all ones.
// The receiver cannot stall; each result shows for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "min_image_distance_3d_assert.svh"

module min_image_distance_3d (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output      logic                          busy,
  input  wire mid3d_pkg::in_item_t           item_i,
  output      logic                          done_o,
  output      mid3d_pkg::out_item_t          result_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mid3d_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);
  import mid3d_pkg::*;

  logic                   accept;
  logic [LATENCY-1:0]     vld_d;
  logic [LATENCY-1:0]     vld_q;

  logic [LEN_W-1:0]       box_len_q [NUM_AXES];
  logic [INV_W-1:0]       inv_box_q [NUM_AXES];
  logic                   cfg_wr;
  logic [REG_IDX_W-1:0]   reg_idx;

  logic [COORD_WIDTH-1:0] first_s  [NUM_AXES];
  logic [COORD_WIDTH-1:0] second_s [NUM_AXES];
  lane_cfg_t [NUM_AXES-1:0] lane_cfg;
  lane_out_t [NUM_AXES-1:0] lane_out;

  assign busy   = 1'b0;
  assign pready = 1'b1;
  assign accept = start && !busy;

  assign vld_d = {vld_q[LATENCY-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[LATENCY-1];

  // Configuration registers
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        box_len_q[i] <= BOX_LEN_RST;
        inv_box_q[i] <= INV_BOX_RST;
      end
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_BOX_LEN_X: box_len_q[0] <= pwdata[LEN_W-1:0];
        REG_BOX_LEN_Y: box_len_q[1] <= pwdata[LEN_W-1:0];
        REG_BOX_LEN_Z: box_len_q[2] <= pwdata[LEN_W-1:0];
        REG_INV_BOX_X: inv_box_q[0] <= pwdata[INV_W-1:0];
        REG_INV_BOX_Y: inv_box_q[1] <= pwdata[INV_W-1:0];
        REG_INV_BOX_Z: inv_box_q[2] <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_BOX_LEN_X: prdata = 32'(box_len_q[0]);
      REG_BOX_LEN_Y: prdata = 32'(box_len_q[1]);
      REG_BOX_LEN_Z: prdata = 32'(box_len_q[2]);
      REG_INV_BOX_X: prdata = inv_box_q[0];
      REG_INV_BOX_Y: prdata = inv_box_q[1];
      REG_INV_BOX_Z: prdata = inv_box_q[2];
      default:       prdata = '0;
    endcase
  end

  // Axis lanes
  assign first_s[0]  = item_i.first_x;
  assign first_s[1]  = item_i.first_y;
  assign first_s[2]  = item_i.first_z;
  assign second_s[0] = item_i.second_x;
  assign second_s[1] = item_i.second_y;
  assign second_s[2] = item_i.second_z;

  for (genvar a = 0; a < NUM_AXES; a++) begin : g_lane
    assign lane_cfg[a].box_len = box_len_q[a];
    assign lane_cfg[a].inv_box = inv_box_q[a];

    mid3d_lane u_lane (
      .clk_i    (clk_i),
      .first_i  (first_s[a]),
      .second_i (second_s[a]),
      .cfg_i    (lane_cfg[a]),
      .out_o    (lane_out[a])
    );
  end

  mid3d_merge u_merge (
    .clk_i    (clk_i),
    .lanes_i  (lane_out),
    .result_o (result_o)
  );

  // Assertions
  `MID3D_ASSERT_IMPL(a_done_has_accept, done_o, $past(accept, LATENCY))
  `MID3D_ASSERT_IMPL(a_zero_dist_zero_disp,
      done_o && (result_o.dist_sq == '0),
      (result_o.disp_x == '0) && (result_o.disp_y == '0) && (result_o.disp_z == '0))
  `MID3D_ASSERT_NEXT(a_box_x_write,
      cfg_wr && (reg_idx == REG_BOX_LEN_X),
      box_len_q[0] == $past(pwdata[LEN_W-1:0]))
  `MID3D_ASSERT_NEXT(a_inv_z_write,
      cfg_wr && (reg_idx == REG_INV_BOX_Z),
      inv_box_q[2] == $past(pwdata))

endmodule

`default_nettype wire

/* sv/mid3d_lane.sv */
// One axis lane: difference, rounded quotient, wrap and square, six stages.
`timescale 1ns / 1ps
`default_nettype none

module mid3d_lane (
  input  wire logic                             clk_i,
  input  wire logic [mid3d_pkg::COORD_WIDTH-1:0] first_i,
  input  wire logic [mid3d_pkg::COORD_WIDTH-1:0] second_i,
  input  wire mid3d_pkg::lane_cfg_t             cfg_i,
  output      mid3d_pkg::lane_out_t             out_o
);
  import mid3d_pkg::*;

  localparam int CW = COORD_WIDTH;

  // stage 1: exact difference and its magnitude
  logic [CW:0]     diff_d;
  logic [CW:0]     mag_d;
  logic [CW-1:0]   d1_q;
  logic            neg1_q;
  logic [CW:0]     mag1_q;

  // stage 2: partial products of |d| * inv
  logic [MAG_W-1:0]   mag_ext;
  logic [63:0]        lo_prod_d;
  logic [HI_W+31:0]   hi_prod_d;
  logic [63:0]        lo_prod_q;
  logic [HI_W+31:0]   hi_prod_q;
  logic [CW-1:0]      d2_q;
  logic               neg2_q;

  // stage 3: round half away from zero
  logic [ACC_W-1:0] rnd_sum;
  logic [Q_W-1:0]   q_d;
  logic [Q_W-1:0]   q_q;
  logic [CW-1:0]    d3_q;
  logic             neg3_q;

  // stage 4: q * L
  logic [QL_W-1:0] ql_full;
  logic [CW-1:0]   ql_d;
  logic [CW-1:0]   ql_q;
  logic [CW-1:0]   d4_q;
  logic            neg4_q;

  // stage 5: wrapped displacement and its magnitude
  logic [CW-1:0] disp_d;
  logic [CW-1:0] dm_d;
  logic [CW-1:0] disp5_q;
  logic [CW-1:0] dm5_q;

  // stage 6: saturating square
  logic [63:0] dm_ext;
  logic [63:0] sq_d;
  logic [63:0] sq6_q;
  logic [CW-1:0] disp6_q;

  always_comb begin
    diff_d = {second_i[CW-1], second_i} - {first_i[CW-1], first_i};
    mag_d  = diff_d[CW] ? (~diff_d + (CW+1)'(1)) : diff_d;
  end

  always_comb begin
    mag_ext   = MAG_W'(mag1_q);
    lo_prod_d = {32'b0, mag_ext[31:0]} * {32'b0, cfg_i.inv_box};
    hi_prod_d = (HI_W+32)'(mag_ext[MAG_W-1:32]) * (HI_W+32)'(cfg_i.inv_box);
  end

  always_comb begin
    rnd_sum = ACC_W'({hi_prod_q, 32'b0}) + ACC_W'(lo_prod_q)
            + (ACC_W'(1) << (FRAC_Q - 1));
    q_d = rnd_sum[FRAC_Q +: Q_W];
  end

  always_comb begin
    ql_full = QL_W'(q_q) * QL_W'(cfg_i.box_len);
    ql_d    = ql_full[CW-1:0];
  end

  always_comb begin
    disp_d = neg4_q ? (d4_q + ql_q) : (d4_q - ql_q);
    dm_d   = disp_d[CW-1] ? (~disp_d + CW'(1)) : disp_d;
  end

  always_comb begin
    dm_ext = 64'(dm5_q);
    // a magnitude of 2^32 or more squares past the range
    if (|dm_ext[63:32]) begin
      sq_d = '1;
    end else begin
      sq_d = {32'b0, dm_ext[31:0]} * {32'b0, dm_ext[31:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q      <= diff_d[CW-1:0];
    neg1_q    <= diff_d[CW];
    mag1_q    <= mag_d;
    lo_prod_q <= lo_prod_d;
    hi_prod_q <= hi_prod_d;
    d2_q      <= d1_q;
    neg2_q    <= neg1_q;
    q_q       <= q_d;
    d3_q      <= d2_q;
    neg3_q    <= neg2_q;
    ql_q      <= ql_d;
    d4_q      <= d3_q;
    neg4_q    <= neg3_q;
    disp5_q   <= disp_d;
    dm5_q     <= dm_d;
    sq6_q     <= sq_d;
    disp6_q   <= disp5_q;
  end

  assign out_o.disp = disp6_q;
  assign out_o.sq   = sq6_q;

endmodule

`default_nettype wire

/* sv/mid3d_merge.sv */
// Merge stage: saturating sum of the lane squares over two stages, with the lane displacements carried alongside.
`timescale 1ns / 1ps
`default_nettype none

module mid3d_merge (
  input  wire logic                                      clk_i,
  input  wire mid3d_pkg::lane_out_t [mid3d_pkg::NUM_AXES-1:0] lanes_i,
  output      mid3d_pkg::out_item_t                      result_o
);
  import mid3d_pkg::*;

  logic [DIST_W:0]      sum01_full;
  logic [DIST_W-1:0]    sum01_d;
  logic [DIST_W-1:0]    sum01_q;
  logic [DIST_W-1:0]    sq2_q;
  lane_out_t [NUM_AXES-1:0] lanes_q;

  logic [DIST_W:0]      total_full;
  logic [DIST_W-1:0]    total_d;
  out_item_t            result_d;
  out_item_t            result_q;

  always_comb begin
    sum01_full = {1'b0, lanes_i[0].sq} + {1'b0, lanes_i[1].sq};
    sum01_d    = sum01_full[DIST_W] ? '1 : sum01_full[DIST_W-1:0];
  end

  always_comb begin
    total_full = {1'b0, sum01_q} + {1'b0, sq2_q};
    total_d    = total_full[DIST_W] ? '1 : total_full[DIST_W-1:0];
    result_d.disp_x  = lanes_q[0].disp;
    result_d.disp_y  = lanes_q[1].disp;
    result_d.disp_z  = lanes_q[2].disp;
    result_d.dist_sq = total_d;
  end

  always_ff @(posedge clk_i) begin
    sum01_q  <= sum01_d;
    sq2_q    <= lanes_i[2].sq;
    lanes_q  <= lanes_i;
    result_q <= result_d;
  end

  assign result_o = result_q;

endmodule

`default_nettype wire
